// File: hdl/hipc_pkg.sv
`default_nettype none
package hipc_pkg;

  localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;

  localparam logic [7:0] NH_HOP    = 8'd0;
  localparam logic [7:0] NH_ROUTE  = 8'd43;
  localparam logic [7:0] NH_FRAG   = 8'd44;
  localparam logic [7:0] NH_AH     = 8'd51;
  localparam logic [7:0] NH_ICMP6  = 8'd58;
  localparam logic [7:0] NH_NONE   = 8'd59;
  localparam logic [7:0] NH_DEST   = 8'd60;
  localparam logic [3:0] VER_4     = 4'd4;
  localparam logic [3:0] VER_6     = 4'd6;
  localparam logic [16:0] V6_FIXED_LEN = 17'd40;

  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_V4       = 4'd1,
    PH_V6_FIXED = 4'd2,
    PH_V6_WALK  = 4'd3,
    PH_V6_DONE  = 4'd4,
    PH_V6_LATER = 4'd5,
    PH_OTHER    = 4'd6
  } phase_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [15:0] payload_offset;
    logic [31:0] frag_id;
    logic        id_valid;
    logic        mf_flag;
    logic        is_mld;
  } result_t;

  typedef struct packed {
    logic full;
    logic push;
  } q_ctl_t;

  function automatic logic is_ext(input logic [7:0] nh);
    return nh == NH_HOP || nh == NH_ROUTE || nh == NH_FRAG || nh == NH_AH || nh == NH_DEST;
  endfunction

  function automatic logic is_mld_type(input logic [7:0] t);
    return t == 8'd130 || t == 8'd131 || t == 8'd132 || t == 8'd143;
  endfunction

endpackage
`default_nettype wire

// File: hdl/hipc_if.sv
`default_nettype none
interface hipc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] pkt_len;
  logic        last;
  modport source (output valid, data_byte, pkt_len, last, input ready);
  modport sink (input valid, data_byte, pkt_len, last, output ready);
endinterface

interface hipc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  protocol;
  logic [15:0] payload_offset;
  logic [31:0] frag_id;
  logic        id_valid;
  logic        mf_flag;
  logic        is_mld;
  modport source (output valid, protocol, payload_offset, frag_id, id_valid, mf_flag,
                  is_mld, input ready);
  modport sink (input valid, protocol, payload_offset, frag_id, id_valid, mf_flag,
                is_mld, output ready);
endinterface
`default_nettype wire

// File: hdl/hipc_front.sv
`default_nettype none
module hipc_front
  import hipc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    ipv6_en,
  hipc_in_if.sink      in_ch,
  input  wire logic    q_full,
  output q_ctl_t       q_ctl,
  output result_t      res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] bc_r, bc_nxt;
  logic [7:0]  cnh_r, cnh_nxt;
  logic [16:0] hs_r, hs_nxt;
  logic [11:0] hl_r, hl_nxt;
  logic [5:0]  v4hl_r, v4hl_nxt;
  logic [15:0] ff_r, ff_nxt;
  logic [31:0] id_r, id_nxt;
  logic        fid_r, fid_nxt;
  logic        fmld_r, fmld_nxt;
  logic [7:0]  rp_r, rp_nxt;

  logic        acc, take;
  logic [15:0] p, len;
  logic [7:0]  d;
  logic [16:0] r;
  logic        below_hs;

  assign in_ch.ready = !q_full;
  assign acc      = in_ch.valid && in_ch.ready;
  assign p        = bc_r;
  assign d        = in_ch.data_byte;
  assign take     = acc && (p < in_ch.pkt_len) && (p < MAX_PACKET_BYTES);
  assign below_hs = {1'b0, p} < hs_r;
  assign r        = {1'b0, p} - hs_r;

  // next state: per-byte parse
  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    cnh_nxt   = cnh_r;
    hs_nxt    = hs_r;
    hl_nxt    = hl_r;
    v4hl_nxt  = v4hl_r;
    ff_nxt    = ff_r;
    id_nxt    = id_r;
    fid_nxt   = fid_r;
    fmld_nxt  = fmld_r;
    rp_nxt    = rp_r;
    if (take) begin
      bc_nxt = p + 16'd1;
      unique case (phase_r)
        PH_VERSION: begin
          if (d[7:4] == VER_4) begin
            v4hl_nxt  = {d[3:0], 2'b00};
            phase_nxt = PH_V4;
          end else if (d[7:4] == VER_6 && ipv6_en) begin
            hs_nxt    = V6_FIXED_LEN;
            phase_nxt = PH_V6_FIXED;
          end else begin
            phase_nxt = PH_OTHER;
          end
        end
        PH_V4: begin
          if (p == 16'd4) id_nxt[15:8] = d;
          if (p == 16'd5) id_nxt[7:0]  = d;
          if (p == 16'd6) ff_nxt[15:8] = d;
          if (p == 16'd7) ff_nxt[7:0]  = d;
          if (p == 16'd9) rp_nxt       = d;
        end
        PH_V6_FIXED: begin
          if (p == 16'd6) cnh_nxt = d;
          if (p == 16'd39) begin
            hl_nxt    = '0;
            phase_nxt = PH_V6_WALK;
          end
        end
        PH_V6_WALK: begin
          if (!below_hs) begin
            if (r == 17'd0) begin
              if (!is_ext(cnh_r)) begin
                phase_nxt = PH_V6_DONE;
                if (cnh_r == NH_ICMP6 && is_mld_type(d)) fmld_nxt = 1'b1;
              end else begin
                rp_nxt = d;
                hl_nxt = '0;
                if (cnh_r == NH_FRAG) begin
                  hl_nxt  = 12'd8;
                  ff_nxt  = '0;
                  id_nxt  = '0;
                  fid_nxt = 1'b1;
                end
              end
            end else begin
              if (r == 17'd1) begin
                if (cnh_r == NH_AH) hl_nxt = {({2'b00, d} + 10'd2), 2'b00};
                else if (cnh_r != NH_FRAG) hl_nxt = {({1'b0, d} + 9'd1), 3'b000};
              end
              if (cnh_r == NH_FRAG) begin
                if (r == 17'd2) ff_nxt[15:8]  = d;
                if (r == 17'd3) ff_nxt[7:0]   = d;
                if (r == 17'd4) id_nxt[31:24] = d;
                if (r == 17'd5) id_nxt[23:16] = d;
                if (r == 17'd6) id_nxt[15:8]  = d;
                if (r == 17'd7) id_nxt[7:0]   = d;
              end
              // a header never ends on its second byte, so the stored length holds here
              if (r != 17'd1 && hl_r != '0 && r == {5'd0, hl_r} - 17'd1) begin
                if (cnh_r == NH_FRAG && ff_r[15:3] != '0) begin
                  phase_nxt = PH_V6_LATER;
                end else begin
                  hs_nxt  = hs_r + {5'd0, hl_r};
                  cnh_nxt = rp_r;
                  hl_nxt  = '0;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // outputs: result from the post-byte state
  always_comb begin
    len = (bc_nxt < in_ch.pkt_len) ? bc_nxt : in_ch.pkt_len;
    res = '0;
    unique case (phase_nxt)
      PH_V4: begin
        if (len >= {10'd0, v4hl_nxt}) begin
          res.payload_offset = {10'd0, v4hl_nxt};
          if (ff_nxt[13:0] != '0) begin
            res.id_valid = 1'b1;
            res.frag_id  = {16'd0, id_nxt[15:0]};
          end
          res.mf_flag  = ff_nxt[13];
          res.protocol = (ff_nxt[12:0] != '0) ? NH_FRAG : rp_nxt;
        end
      end
      PH_V6_FIXED, PH_V6_WALK, PH_V6_DONE, PH_V6_LATER: begin
        res.payload_offset = hs_nxt[15:0];
        res.protocol       = cnh_nxt;
        if (phase_nxt == PH_V6_LATER) begin
          res.protocol = NH_FRAG;
        end else if (phase_nxt == PH_V6_DONE) begin
          res.is_mld = fmld_nxt;
        end else if ({1'b0, len} > hs_nxt) begin
          res.protocol = (cnh_nxt == NH_FRAG && ff_nxt[15:3] != '0) ? NH_FRAG : NH_NONE;
        end
        if (fid_nxt) begin
          res.id_valid = 1'b1;
          res.frag_id  = id_nxt;
          res.mf_flag  = ff_nxt[0];
        end
      end
      default: ;
    endcase
    q_ctl.full = q_full;
    q_ctl.push = acc && in_ch.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_ch.last)) begin
      phase_r <= PH_VERSION;
      bc_r    <= '0;
      cnh_r   <= '0;
      hs_r    <= '0;
      hl_r    <= '0;
      v4hl_r  <= '0;
      ff_r    <= '0;
      id_r    <= '0;
      fid_r   <= 1'b0;
      fmld_r  <= 1'b0;
      rp_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      cnh_r   <= cnh_nxt;
      hs_r    <= hs_nxt;
      hl_r    <= hl_nxt;
      v4hl_r  <= v4hl_nxt;
      ff_r    <= ff_nxt;
      id_r    <= id_nxt;
      fid_r   <= fid_nxt;
      fmld_r  <= fmld_nxt;
      rp_r    <= rp_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/hipc_queue.sv
`default_nettype none
module hipc_queue
  import hipc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  q_ctl_t       q_ctl,
  input  result_t      res,
  output logic         q_full,
  hipc_out_if.source   out_ch
);

  result_t     mem_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign q_full = cnt_r == 2'd2;
  assign pop    = out_ch.valid && out_ch.ready;

  always_comb begin
    wp_nxt  = wp_r ^ q_ctl.push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, q_ctl.push} - {1'b0, pop};
  end

  assign out_ch.valid          = cnt_r != 2'd0;
  assign out_ch.protocol       = mem_r[rp_r].protocol;
  assign out_ch.payload_offset = mem_r[rp_r].payload_offset;
  assign out_ch.frag_id        = mem_r[rp_r].frag_id;
  assign out_ch.id_valid       = mem_r[rp_r].id_valid;
  assign out_ch.mf_flag        = mem_r[rp_r].mf_flag;
  assign out_ch.is_mld         = mem_r[rp_r].is_mld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ctl.push) mem_r[wp_r] <= res;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_ctl.push && q_ctl.full)) else $error("push into full queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) == (wp_r != rp_r)) else $error("queue pointers disagree with count");
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.push |=> out_ch.valid) else $error("pushed result not visible");

endmodule
`default_nettype wire

// File: hdl/ip_header_protocol_classifier_core.sv
`default_nettype none
// IP header protocol classifier. Feed the bytes of one packet, from the IP header
// on, one transfer per cycle with pkt_len alongside and last on the final byte;
// one result transfer follows for each packet, carrying the upper protocol, its
// header offset and fragment information. For each byte the parser advances
// a byte counter and a few compares, and the result of a packet
// is formed in the cycle its final byte is taken and written to a two-entry
// result queue. Input stalls only while that queue holds two unread results.
// Bytes at or beyond pkt_len, or at position 65535 or later, are dropped without
// effect. IPv4 reports protocol 44 for a fragment with nonzero offset; IPv6 walks
// hop-by-hop, routing, fragment, AH and destination-option headers, gives 59 for a
// header cut by the packet end and 44 for a later fragment. cfg_wr_en with
// cfg_wr_data writes ipv6_enable (reset 1); clear it to report version 6 packets
// as zero. Write it only while no packet is in progress.
module ip_header_protocol_classifier_core
  import hipc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data,
  hipc_in_if.sink    in_ch,
  hipc_out_if.source out_ch
);

  logic    ipv6_en_r;
  logic    q_full;
  q_ctl_t  q_ctl;
  result_t res;

  // hold the enable; sampled by the parser at the version byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipv6_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      ipv6_en_r <= cfg_wr_data;
    end
  end

  // front: byte parser, pushes one result per packet
  hipc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .ipv6_en (ipv6_en_r),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_ctl   (q_ctl),
    .res     (res)
  );

  // back: result queue driving the output channel
  hipc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_ctl  (q_ctl),
    .res    (res),
    .q_full (q_full),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// File: tb/tb_ip_header_protocol_classifier_core.sv
`timescale 1ns / 1ps
module tb_ip_header_protocol_classifier_core;
  import hipc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int BYTES_PER_PHASE = 230;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;

  hipc_in_if in_ch ();
  hipc_out_if out_ch ();

  ip_header_protocol_classifier_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #2 clk = ~clk;

  // Expected classifications, oldest first.
  result_t expected_q[$];
  int fail_count = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  // Shadow of the parser state, updated on every accepted byte.
  bit          v6_en;
  bit [31:0]   s_count;
  phase_t      s_phase;
  bit [7:0]    s_nh;
  bit [31:0]   s_start;
  bit [31:0]   s_hlen;
  bit [31:0]   s_v4len;
  bit [31:0]   s_frag;
  bit [31:0]   s_id;
  bit          s_id_seen;
  bit          s_mld_seen;
  bit [7:0]    s_proto;

  function automatic void clear_parser();
    s_count = 0; s_phase = PH_VERSION; s_nh = 0; s_start = 0; s_hlen = 0;
    s_v4len = 0; s_frag = 0; s_id = 0; s_id_seen = 0; s_mld_seen = 0; s_proto = 0;
  endfunction

  function automatic bit chained(input bit [7:0] nh);
    case (nh)
      NH_HOP, NH_ROUTE, NH_FRAG, NH_AH, NH_DEST: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Advance the IPv6 extension walk by one byte at position p.
  function automatic void walk_chain(input bit [31:0] p, input bit [7:0] d);
    bit [31:0] r;
    if (p < s_start) return;
    r = p - s_start;
    if (r == 0) begin
      if (!chained(s_nh)) begin
        s_phase = PH_V6_DONE;
        if (s_nh == NH_ICMP6 && (d == 8'd130 || d == 8'd131 || d == 8'd132 || d == 8'd143))
          s_mld_seen = 1'b1;
        return;
      end
      s_proto = d;
      s_hlen = 0;
      if (s_nh == NH_FRAG) begin
        s_hlen = 8; s_frag = 0; s_id = 0; s_id_seen = 1'b1;
      end
      return;
    end
    if (r == 1) begin
      if (s_nh == NH_AH) s_hlen = (32'(d) + 2) << 2;
      else if (s_nh != NH_FRAG) s_hlen = (32'(d) + 1) << 3;
    end
    if (s_nh == NH_FRAG) begin
      if (r == 2 || r == 3) s_frag |= 32'(d) << (8 * (3 - r));
      else if (r >= 4 && r <= 7) s_id |= 32'(d) << (8 * (7 - r));
    end
    if (s_hlen != 0 && r == s_hlen - 1) begin
      if (s_nh == NH_FRAG && (s_frag & 32'hFFF8) != 0) begin
        s_phase = PH_V6_LATER;
        return;
      end
      s_start = (s_start + s_hlen) & 32'h1FFFF;
      s_nh = s_proto;
      s_hlen = 0;
    end
  endfunction

  // Classify one accepted byte; got is set when the packet ends here.
  function automatic void classify_byte(input bit [7:0] d, input bit [15:0] plen,
                                        input bit last, output bit got, output result_t r);
    bit [31:0] p, len;
    p = s_count;
    got = 1'b0;
    r = '0;
    if (p < plen && p < 32'(MAX_PACKET_BYTES)) begin
      case (s_phase)
        PH_VERSION: begin
          if (d[7:4] == VER_4) begin
            s_v4len = 32'(d[3:0]) << 2;
            s_phase = PH_V4;
          end else if (d[7:4] == VER_6 && v6_en) begin
            s_start = 40;
            s_phase = PH_V6_FIXED;
          end else begin
            s_phase = PH_OTHER;
          end
        end
        PH_V4: begin
          if (p == 4 || p == 5) s_id |= 32'(d) << (8 * (5 - p));
          else if (p == 6 || p == 7) s_frag |= 32'(d) << (8 * (7 - p));
          else if (p == 9) s_proto = d;
        end
        PH_V6_FIXED: begin
          if (p == 6) s_nh = d;
          if (p == 39) begin
            s_hlen = 0;
            s_phase = PH_V6_WALK;
          end
        end
        PH_V6_WALK: walk_chain(p, d);
        default: ;
      endcase
      s_count = p + 1;
    end
    if (!last) return;
    got = 1'b1;
    len = (s_count < plen) ? s_count : 32'(plen);
    if (s_phase == PH_V4) begin
      if (len >= s_v4len) begin
        r.payload_offset = s_v4len[15:0];
        if ((s_frag & 32'h3FFF) != 0) begin
          r.id_valid = 1'b1;
          r.frag_id = s_id;
        end
        r.mf_flag = s_frag[13];
        r.protocol = ((s_frag & 32'h1FFF) != 0) ? NH_FRAG : s_proto;
      end
    end else if (s_phase inside {PH_V6_FIXED, PH_V6_WALK, PH_V6_DONE, PH_V6_LATER}) begin
      r.payload_offset = s_start[15:0];
      r.protocol = s_nh;
      if (s_phase == PH_V6_LATER) begin
        r.protocol = NH_FRAG;
      end else if (s_phase == PH_V6_DONE) begin
        r.is_mld = s_mld_seen;
      end else if (len > s_start) begin
        r.protocol = (s_nh == NH_FRAG && (s_frag & 32'hFFF8) != 0) ? NH_FRAG : NH_NONE;
      end
      if (s_id_seen) begin
        r.id_valid = 1'b1;
        r.frag_id = s_id;
        r.mf_flag = s_frag[0];
      end
    end
    clear_parser();
  endfunction

  // Offer one byte, hold it until the transfer, then log the expectation.
  task automatic send_byte(input bit [7:0] d, input bit [15:0] plen, input bit last);
    bit got;
    result_t r;
    while ($urandom_range(99) < tx_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.pkt_len <= plen;
    in_ch.last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    classify_byte(d, plen, last, got, r);
    if (got) expected_q.push_back(r);
  endtask

  // Send a built packet: pick pkt_len and how many bytes actually go out.
  task automatic send_packet(input bit [7:0] pkt[$]);
    int total, sent, sel;
    bit [15:0] plen;
    total = pkt.size();
    sel = $urandom_range(99);
    if (sel < 70) plen = 16'(total);
    else if (sel < 90) plen = 16'($urandom_range(total));
    else plen = 16'($urandom);
    sent = ($urandom_range(99) < 80) ? total : $urandom_range(total + 3, 1);
    while (pkt.size() < sent) pkt.push_back(8'($urandom));
    for (int i = 0; i < sent; i++) send_byte(pkt[i], plen, i == sent - 1);
  endtask

  function automatic void build_v4(ref bit [7:0] pkt[$]);
    int ihl, hl, sel;
    bit [15:0] ff;
    ihl = ($urandom_range(99) < 75) ? 5 : $urandom_range(15);
    hl = (ihl * 4 < 20) ? 20 : ihl * 4;
    for (int i = 0; i < hl; i++) pkt.push_back(8'($urandom));
    pkt[0] = {VER_4, 4'(ihl)};
    sel = $urandom_range(3);
    case (sel)
      0: ff = 16'h0000;
      1: ff = 16'h4000;
      2: ff = 16'h2000 | 16'($urandom_range(3));
      default: ff = 16'($urandom);
    endcase
    pkt[6] = ff[15:8];
    pkt[7] = ff[7:0];
    repeat ($urandom_range(4)) pkt.push_back(8'($urandom));
  endfunction

  function automatic bit [7:0] pick_ext();
    case ($urandom_range(4))
      0: return NH_HOP;
      1: return NH_ROUTE;
      2: return NH_FRAG;
      3: return NH_AH;
      default: return NH_DEST;
    endcase
  endfunction

  function automatic void build_v6(ref bit [7:0] pkt[$]);
    bit [7:0] kinds[$];
    bit [7:0] fin, mt;
    int n, hl, base;
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) kinds.push_back(pick_ext());
    case ($urandom_range(5))
      0: fin = 8'd6;
      1: fin = 8'd17;
      2, 3: fin = NH_ICMP6;
      4: fin = 8'd50;
      default: fin = 8'($urandom);
    endcase
    kinds.push_back(fin);
    for (int i = 0; i < 40; i++) pkt.push_back(8'($urandom));
    pkt[0] = {VER_6, pkt[0][3:0]};
    pkt[6] = kinds[0];
    for (int i = 0; i < n; i++) begin
      base = pkt.size();
      if (kinds[i] == NH_FRAG) hl = 8;
      else begin
        mt = 8'($urandom_range(2));
        hl = (kinds[i] == NH_AH) ? (int'(mt) + 2) * 4 : (int'(mt) + 1) * 8;
      end
      for (int j = 0; j < hl; j++) pkt.push_back(8'($urandom));
      pkt[base] = kinds[i + 1];
      if (kinds[i] == NH_FRAG) begin
        if ($urandom_range(1)) begin
          pkt[base + 2] = 8'h00;
          pkt[base + 3] = {5'd0, 2'($urandom), 1'($urandom)};
        end
      end else pkt[base + 1] = mt;
    end
    if (fin == NH_ICMP6) begin
      case ($urandom_range(4))
        0: mt = 8'd130;
        1: mt = 8'd131;
        2: mt = 8'd132;
        3: mt = 8'd143;
        default: mt = 8'($urandom);
      endcase
      pkt.push_back(mt);
    end
    repeat ($urandom_range(6)) pkt.push_back(8'($urandom));
  endfunction

  // Random bytes with pkt_len changing under the packet.
  task automatic send_noise();
    int n;
    n = $urandom_range(12, 1);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), ($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(16))),
                i == n - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_enable(input bit v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    v6_en = v;
  endtask

  // Result side: random backpressure, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_pct);
    end
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result proto=%0d off=%0d", $realtime, out_ch.protocol,
                 out_ch.payload_offset);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.protocol !== want.protocol || out_ch.payload_offset !== want.payload_offset ||
            out_ch.frag_id !== want.frag_id || out_ch.id_valid !== want.id_valid ||
            out_ch.mf_flag !== want.mf_flag || out_ch.is_mld !== want.is_mld) begin
          $display("%0t: mismatch expected %0d/%0d/%h/%b/%b/%b actual %0d/%0d/%h/%b/%b/%b",
                   $realtime, want.protocol, want.payload_offset, want.frag_id, want.id_valid,
                   want.mf_flag, want.is_mld, out_ch.protocol, out_ch.payload_offset,
                   out_ch.frag_id, out_ch.id_valid, out_ch.mf_flag, out_ch.is_mld);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_ip_header_protocol_classifier_core NOT OK");
      $finish;
    end
  end

  typedef struct {
    bit [7:0]  d;
    bit [15:0] plen;
    bit        last;
    bit [7:0]  proto;
    bit [15:0] off;
  } directed_row_t;

  // One-byte packets whose result is known up front.
  directed_row_t directed_rows[5] = '{
    '{8'h00, 16'd1,     1'b1, 8'd0, 16'd0},   // bad version
    '{8'h45, 16'd20,    1'b1, 8'd0, 16'd0},   // IPv4 shorter than its header
    '{8'h60, 16'd0,     1'b1, 8'd0, 16'd0},   // empty packet, byte dropped
    '{8'h60, 16'hFFFF,  1'b1, 8'd0, 16'd40},  // IPv6 cut inside the fixed header
    '{8'hFF, 16'hFFFF,  1'b1, 8'd0, 16'd0}    // all-ones byte, bad version
  };

  initial begin
    bit [7:0] pkt[$];
    bit got;
    result_t r, typed;
    int sent_base, sel;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.pkt_len = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    v6_en = 1'b1;
    clear_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: typed expectations, parser state kept in step.
    foreach (directed_rows[i]) begin
      in_ch.valid <= 1'b1;
      in_ch.data_byte <= directed_rows[i].d;
      in_ch.pkt_len <= directed_rows[i].plen;
      in_ch.last <= directed_rows[i].last;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      classify_byte(directed_rows[i].d, directed_rows[i].plen, directed_rows[i].last, got, r);
      typed = '0;
      typed.protocol = directed_rows[i].proto;
      typed.payload_offset = directed_rows[i].off;
      expected_q.push_back(typed);
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      write_enable(ph != 1);
      case (ph)
        0: begin tx_pct = 0; rx_pct = 0; end
        1: begin tx_pct = 64; rx_pct = 0; end
        2: begin tx_pct = 0; rx_pct = 64; end
        default: begin tx_pct = 20; rx_pct = 20; end
      endcase
      // Starve the result side while bytes keep coming so the input stalls.
      if (ph == 0) hold_cycles = 300;
      sent_base = 0;
      while (sent_base < BYTES_PER_PHASE) begin
        pkt.delete();
        sel = $urandom_range(99);
        if (sel < 40) build_v4(pkt);
        else if (sel < 85) build_v6(pkt);
        if (sel < 85) begin
          sent_base += pkt.size();
          send_packet(pkt);
        end else begin
          send_noise();
          sent_base += 6;
        end
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("tb_ip_header_protocol_classifier_core OK");
    end else begin
      $display("tb_ip_header_protocol_classifier_core NOT OK");
    end
    $finish;
  end

endmodule
